>>> hw/rtl/swm_pkg.sv
// Shared types, constants and helpers for the sliding window maximum block.
`timescale 1ns / 1ps

package swm_pkg;

	localparam int DATA_W         = 32;
	localparam int POS_W          = 32;
	localparam int WS_W           = 7;
	localparam int WINDOW_MAX_DEF = 64;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [WS_W-1:0]          wsize_t;

	// Larger of two signed samples.
	function automatic sample_t swm_max(input sample_t a, input sample_t b);
		swm_max = (a > b) ? a : b;
	endfunction

endpackage

>>> hw/rtl/swm_cell.sv
// One cell of the chain: running maximum over the newest samples up to its age.
`timescale 1ns / 1ps

module swm_cell
	import swm_pkg::*;
(
	input  logic    clk,
	input  logic    en,
	input  sample_t prev_max,
	input  sample_t sample,
	output sample_t cell_max
);

	sample_t cell_max_q;

	// Take the neighbour's maximum one age older, folded with the new sample.
	always_ff @(posedge clk) begin
		if (en) begin
			cell_max_q <= swm_max(prev_max, sample);
		end
	end

	assign cell_max = cell_max_q;

endmodule

>>> hw/rtl/sliding_window_maximum.sv
// Sliding window maximum over a stream of signed samples, built as a chain of max cells.
// Results are registered: a result is valid in the cycle after the sample transfer that causes it.
// Throughput: one sample per cycle; the output register takes a new result in the
// cycle the previous one is taken, so only a stalled output holds off input.
// Reset: asynchronous, clears the live count, fill count, position and output valid
// and sets the window size to 1; the cell contents need no reset.
`timescale 1ns / 1ps

module sliding_window_maximum
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t sample,
	input  logic    start_of_sequence,
	output logic    out_valid,
	input  logic    out_ready,
	output sample_t window_max,
	output pos_t    window_start,
	input  logic    cfg_wr_en,
	input  wsize_t  cfg_wr_data
);

	localparam int LEN_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int CMP_W = (LEN_W > WS_W) ? LEN_W : WS_W;

	wsize_t              ws_q;
	logic [LEN_W-1:0]    live_q;
	logic [LEN_W-1:0]    filled_q;
	pos_t                pos_q;
	logic                out_valid_q;
	sample_t             window_max_q;
	pos_t                window_start_q;

	logic                accept;
	logic [CMP_W-1:0]    ws_ext;
	logic [LEN_W-1:0]    k;
	logic [LEN_W-1:0]    live_base;
	logic [LEN_W:0]      live_inc;
	logic [LEN_W-1:0]    live_nxt;
	logic [LEN_W-1:0]    filled_base;
	logic [LEN_W-1:0]    filled_nxt;
	pos_t                pos_base;
	logic                emit;
	logic [IDX_W-1:0]    sel;
	sample_t             result_max;
	sample_t             cell_max [WINDOW_MAX];

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// Effective window: zero reads as one, anything above the chain length saturates.
	always_comb begin
		ws_ext = CMP_W'(ws_q);
		if (ws_q == '0) begin
			k = LEN_W'(1);
		end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
			k = LEN_W'(WINDOW_MAX);
		end else begin
			k = LEN_W'(ws_ext);
		end
	end

	// The live count is how many of the newest samples still count; it never grows
	// past the window, so samples dropped under a smaller window stay dropped.
	always_comb begin
		live_base   = start_of_sequence ? '0 : live_q;
		filled_base = start_of_sequence ? '0 : filled_q;
		pos_base    = start_of_sequence ? '0 : pos_q;
		live_inc    = {1'b0, live_base} + (LEN_W + 1)'(1);
		live_nxt    = (live_inc > {1'b0, k}) ? k : live_inc[LEN_W-1:0];
		filled_nxt  = (filled_base == LEN_W'(WINDOW_MAX)) ? filled_base
		              : filled_base + LEN_W'(1);
		emit        = filled_nxt >= k;
		sel         = IDX_W'(live_nxt - LEN_W'(1));
		if (sel == '0) begin
			result_max = sample;
		end else begin
			result_max = swm_max(cell_max[sel - IDX_W'(1)], sample);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				swm_cell u_cell (
					.clk      (clk),
					.en       (accept),
					.prev_max (sample),
					.sample   (sample),
					.cell_max (cell_max[gi])
				);
			end else begin : g_body
				swm_cell u_cell (
					.clk      (clk),
					.en       (accept),
					.prev_max (cell_max[gi-1]),
					.sample   (sample),
					.cell_max (cell_max[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= wsize_t'(1);
			live_q      <= '0;
			filled_q    <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ws_q <= cfg_wr_data;
			end
			if (accept) begin
				live_q      <= live_nxt;
				filled_q    <= filled_nxt;
				pos_q       <= pos_base + pos_t'(1);
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			window_max_q   <= result_max;
			window_start_q <= pos_base - pos_t'(k) + pos_t'(1);
		end
	end

	assign out_valid    = out_valid_q;
	assign window_max   = window_max_q;
	assign window_start = window_start_q;

	a_live_le_filled: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= filled_q)
		else $error("live count exceeds fill count");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= LEN_W'(WINDOW_MAX))
		else $error("live count exceeds chain length");

	a_start_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && start_of_sequence |=> live_q == LEN_W'(1) && pos_q == pos_t'(1))
		else $error("start of sequence did not restart counting");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the sliding window maximum block.
`timescale 1ns / 1ps

module testbench;
	import swm_pkg::*;

	localparam int WINDOW      = WINDOW_MAX_DEF;
	localparam int TOTAL_ITEMS = 1650;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 4;

	// Models the window with its own candidate store alongside the block and queues the expected windows.
	class window_max_tracker;
		sample_t     cand_val[WINDOW];
		pos_t        cand_pos[WINDOW];
		int unsigned head;
		int unsigned count;
		int unsigned filled;
		pos_t        next_pos;
		wsize_t      wsize;
		sample_t     exp_max[$];
		pos_t        exp_start[$];
		int unsigned mismatches;

		function new();
			head       = 0;
			count      = 0;
			filled     = 0;
			next_pos   = '0;
			wsize      = wsize_t'(1);
			mismatches = 0;
		endfunction

		function void set_window(wsize_t v);
			wsize = v;
		endfunction

		function int unsigned span();
			if (wsize == 0)
				return 1;
			if (wsize > WINDOW)
				return WINDOW;
			return wsize;
		endfunction

		function int unsigned pending();
			return exp_max.size();
		endfunction

		function void note_sample(sample_t s, logic sos);
			int unsigned k;
			pos_t        p;
			k = span();
			if (sos) begin
				head     = 0;
				count    = 0;
				filled   = 0;
				next_pos = '0;
			end
			p = next_pos;
			// drop candidates that have left the window
			while (count > 0 && pos_t'(p - cand_pos[head]) >= k) begin
				head = (head + 1) % WINDOW;
				count--;
			end
			// drop smaller candidates from the back; a tie keeps the older one
			while (count > 0 && s > cand_val[(head + count - 1) % WINDOW])
				count--;
			if (count < WINDOW) begin
				cand_val[(head + count) % WINDOW] = s;
				cand_pos[(head + count) % WINDOW] = p;
				count++;
			end
			next_pos = p + 1;
			if (filled < WINDOW)
				filled++;
			if (filled >= k) begin
				exp_max.insert(exp_max.size(), cand_val[head]);
				exp_start.insert(exp_start.size(), pos_t'(p - k + 1));
			end
		endfunction

		function void check_result(sample_t got_max, pos_t got_start);
			sample_t em;
			pos_t    es;
			if (exp_max.size() == 0) begin
				$error("unexpected result: window_max %0d, window_start %0d", got_max,
					got_start);
				mismatches++;
				return;
			end
			em = exp_max[0];
			es = exp_start[0];
			exp_max.delete(0);
			exp_start.delete(0);
			if (got_max !== em) begin
				$error("window_max: expected %0d, got %0d", em, got_max);
				mismatches++;
			end
			if (got_start !== es) begin
				$error("window_start: expected %0d, got %0d", es, got_start);
				mismatches++;
			end
		endfunction
	endclass

	logic    clk               = 1'b0;
	logic    arst_n            = 1'b0;
	logic    in_valid          = 1'b0;
	logic    in_ready;
	sample_t sample            = '0;
	logic    start_of_sequence = 1'b0;
	logic    out_valid;
	logic    out_ready         = 1'b0;
	sample_t window_max;
	pos_t    window_start;
	logic    cfg_wr_en         = 1'b0;
	wsize_t  cfg_wr_data       = '0;

	window_max_tracker tracker;
	bit          idle_in     = 1'b0;
	bit          idle_out    = 1'b0;
	bit          hold_output = 1'b0;
	int unsigned quiet_cycles = 0;
	int unsigned sent         = 0;
	sample_t     last_sample  = '0;

	sliding_window_maximum #(.WINDOW_MAX(WINDOW)) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sample            (sample),
		.start_of_sequence (start_of_sequence),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.window_max        (window_max),
		.window_start      (window_start),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Observe every transfer and register write at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				tracker.set_window(cfg_wr_data);
			if (in_valid && in_ready)
				tracker.note_sample(sample, start_of_sequence);
			if (out_valid && out_ready)
				tracker.check_result(window_max, window_start);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				stall = idle_out ? $urandom_range(0, 5) : 0;
			@(negedge clk);
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_sample(input sample_t s, input logic sos);
		int gap;
		gap = idle_in ? $urandom_range(0, 5) : 0;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		sample            <= s;
		start_of_sequence <= sos;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		sent++;
		last_sample = s;
	endtask

	// Hold input until every expected window has arrived, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_window(input wsize_t v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_burst(input sample_t vals[$], input logic first_start);
		foreach (vals[i])
			send_sample(vals[i], first_start && i == 0);
	endtask

	function automatic sample_t draw_sample();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return sample_t'($urandom_range(0, 16) - 8);
		if (pick < 7)
			return sample_t'($urandom);
		if (pick == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return '0;
				default: return '1;
			endcase
		end
		// ramp up or down from the previous sample
		if ($urandom_range(0, 1))
			return last_sample + sample_t'($urandom_range(0, 3));
		return last_sample - sample_t'($urandom_range(0, 3));
	endfunction

	function automatic wsize_t draw_window();
		case ($urandom_range(0, 3))
			0, 1: return wsize_t'($urandom_range(1, 8));
			2: return wsize_t'($urandom_range(0, 127));
			default: begin
				case ($urandom_range(0, 6))
					0: return 7'd0;
					1: return 7'd1;
					2: return 7'd2;
					3: return 7'd63;
					4: return 7'd64;
					5: return 7'd65;
					default: return 7'd127;
				endcase
			end
		endcase
	endfunction

	initial begin : stimulus
		sample_t     burst[$];
		int unsigned len;
		int unsigned k;
		bit          well_formed;
		bit          with_start;

		tracker = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first samples after reset, no start flag, window of one
		burst = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1};
		send_burst(burst, 1'b0);
		// zero window behaves as one
		write_window(7'd0);
		burst = '{7, -3};
		send_burst(burst, 1'b1);
		// ties, back drops and front eviction
		write_window(7'd3);
		burst = '{4, 4, 2, 9, 1, 0, -5, -7, 32'sh7FFF_FFFF};
		send_burst(burst, 1'b1);
		// oversized window saturates; this sequence stays too short to emit
		write_window(7'd127);
		burst = '{1, 2, 3, 4};
		send_burst(burst, 1'b1);
		// shrink the window mid-sequence
		write_window(7'd2);
		burst = '{-8, 32'sh8000_0000};
		send_burst(burst, 1'b0);

		// back-pressure: receiver holds off while the sender streams
		write_window(7'd1);
		idle_in     = 1'b0;
		idle_out    = 1'b0;
		hold_output = 1'b1;
		repeat (60)
			send_sample(draw_sample(), 1'b0);
		drain();

		while (sent < TOTAL_ITEMS) begin
			idle_in  = $urandom_range(0, 2) != 0;
			idle_out = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 9) < 7)
				write_window(draw_window());
			k           = tracker.span();
			well_formed = $urandom_range(0, 99) < 85;
			if (well_formed) begin
				len        = k + $urandom_range(0, 2 * k + 4);
				with_start = $urandom_range(0, 9) != 0;
				for (int i = 0; i < len; i++)
					send_sample(draw_sample(), with_start && i == 0);
			end else begin
				len = $urandom_range(1, 2 * k + 8);
				for (int i = 0; i < len; i++)
					send_sample(draw_sample(), $urandom_range(0, 7) == 0);
			end
			drain();
		end

		drain();
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sliding_window_maximum.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_maximum.sv
tb/sv/testbench.sv
